// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the encoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent on the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/b64e_pkg.sv -----
// Shared types, constants and the sextet-to-ASCII mapping for the Base64 encoder
`timescale 1ns / 1ps

package b64e_pkg;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;

	localparam logic [6:0] CHAR_PAD        = 7'h3D;
	localparam logic [6:0] CHAR_PLUS       = 7'h2B;
	localparam logic [6:0] CHAR_SLASH      = 7'h2F;
	localparam logic [6:0] CHAR_MINUS      = 7'h2D;
	localparam logic [6:0] CHAR_UNDERSCORE = 7'h5F;
	localparam logic [6:0] CHAR_UPPER_A    = 7'h41;
	localparam logic [6:0] CHAR_LOWER_A    = 7'h61;
	localparam logic [6:0] CHAR_DIGIT_0    = 7'h30;

	localparam logic [5:0] SEXTET_LAST_UPPER = 6'd25;
	localparam logic [5:0] SEXTET_LAST_LOWER = 6'd51;
	localparam logic [5:0] SEXTET_LAST_DIGIT = 6'd61;
	localparam logic [5:0] SEXTET_PLUS       = 6'd62;
	localparam logic [6:0] LOWER_OFFSET      = 7'd26;
	localparam logic [6:0] DIGIT_OFFSET      = 7'd52;

	typedef struct packed {
		logic [3:0][6:0] chars;
		logic [1:0]      last_idx;
		logic            eot;
	} job_t;

	function automatic logic [6:0] sextet_char(input logic [5:0] v, input logic url);
		logic [6:0] c;
		if (v <= SEXTET_LAST_UPPER) begin
			c = CHAR_UPPER_A + {1'b0, v};
		end else if (v <= SEXTET_LAST_LOWER) begin
			c = CHAR_LOWER_A + {1'b0, v} - LOWER_OFFSET;
		end else if (v <= SEXTET_LAST_DIGIT) begin
			c = CHAR_DIGIT_0 + {1'b0, v} - DIGIT_OFFSET;
		end else if (v == SEXTET_PLUS) begin
			c = url ? CHAR_MINUS : CHAR_PLUS;
		end else begin
			c = url ? CHAR_UNDERSCORE : CHAR_SLASH;
		end
		return c;
	endfunction

endpackage

// ----- rtl/b64e_front.sv -----
// Front end: accepts bytes, tracks group position and builds character jobs
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64e_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               url_safe,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic               q_ready,
	output logic               in_ready,
	output logic               push,
	output b64e_pkg::job_t     push_job
);

	logic [1:0] pos_q;
	logic [5:0] left_q;
	logic [1:0] npos;
	logic [5:0] nleft;
	logic [5:0] s0;
	logic [5:0] s1;
	logic       accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;
	assign push     = accept;

	always_comb begin
		unique case (pos_q)
			b64e_pkg::POS_SECOND: begin
				s0    = {2'b00, in_byte[7:4]} | left_q;
				s1    = {in_byte[3:0], 2'b00};
				nleft = s1;
				npos  = b64e_pkg::POS_THIRD;
			end
			b64e_pkg::POS_THIRD: begin
				s0    = {4'b0000, in_byte[7:6]} | left_q;
				s1    = in_byte[5:0];
				nleft = '0;
				npos  = b64e_pkg::POS_FIRST;
			end
			default: begin
				s0    = in_byte[7:2];
				s1    = {in_byte[1:0], 4'b0000};
				nleft = s1;
				npos  = b64e_pkg::POS_SECOND;
			end
		endcase
	end

	always_comb begin
		push_job.chars[0] = b64e_pkg::sextet_char(s0, url_safe);
		push_job.chars[1] = b64e_pkg::sextet_char(s1, url_safe);
		push_job.chars[2] = b64e_pkg::CHAR_PAD;
		push_job.chars[3] = b64e_pkg::CHAR_PAD;
		push_job.eot      = in_last;
		if (in_last) begin
			unique case (npos)
				b64e_pkg::POS_SECOND: push_job.last_idx = 2'd3;
				b64e_pkg::POS_THIRD:  push_job.last_idx = 2'd2;
				default:              push_job.last_idx = 2'd1;
			endcase
		end else begin
			push_job.last_idx = (pos_q == b64e_pkg::POS_THIRD) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= b64e_pkg::POS_FIRST;
			left_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				pos_q  <= b64e_pkg::POS_FIRST;
				left_q <= '0;
			end else begin
				pos_q  <= npos;
				left_q <= nleft;
			end
		end
	end

	`ASSERT_NEXT(a_last_clears, accept && in_last, pos_q == b64e_pkg::POS_FIRST && left_q == '0, "state not cleared after last byte")
	`ASSERT_NEXT(a_group_done, accept && pos_q == b64e_pkg::POS_THIRD, left_q == '0, "leftover kept after completed group")

endmodule

// ----- rtl/b64e_queue.sv -----
// Short job queue between the front end and the character serializer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64e_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64e_pkg::job_t push_job,
	output logic           push_ready,
	input  logic           pop,
	output logic           head_valid,
	output b64e_pkg::job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64e_pkg::job_t   store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             full;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign push_ready = !full;
	assign head_valid = (cnt_q != '0);
	assign head_job   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
	`ASSERT_NEVER(a_no_underflow, pop && !head_valid, "pop from empty queue")

endmodule

// ----- rtl/b64e_back.sv -----
// Back end: sends one character of the head job per transfer through an output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  b64e_pkg::job_t head_job,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);

	logic [1:0] idx_q;
	logic       m_tvalid_q;
	logic [6:0] char_q;
	logic       eot_q;
	logic       load;
	logic       at_end;

	assign load     = head_valid && (!m_tvalid_q || m_tready);
	assign at_end   = (idx_q == head_job.last_idx);
	assign pop      = load && at_end;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = eot_q;

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head_job.chars[idx_q];
			eot_q  <= head_job.eot && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q      <= at_end ? 2'd0 : idx_q + 2'd1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEVER(a_idx_in_job, head_valid && idx_q > head_job.last_idx, "character index past end of job")

endmodule

// ----- rtl/base64_stream_encoder.sv -----
// Top level of the Base64 stream encoder
// Encodes a byte stream into Base64 text, standard or URL-safe alphabet per cfg_wr_data.
// Each byte is turned into a job of one to four characters in the cycle it transfers
// in; jobs wait in a QUEUE_DEPTH-entry queue and leave one character per cycle through
// a registered output while m_tready allows. A byte transfers in every cycle while the
// queue has room; the character serializer bounds the sustained rate at one character
// per cycle, four characters for every three-byte group, and the last byte of a message
// makes up to four characters: its own, a leftover character and padding.
`timescale 1ns / 1ps

module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,  // url_safe_alphabet
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,      // [7:0] data_byte
	input  logic       s_tlast,      // last_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,      // [6:0] out_char, [7] zero
	output logic       m_tlast       // end_of_text
);

	logic           url_q;
	logic           q_ready;
	logic           push;
	b64e_pkg::job_t push_job;
	logic           pop;
	logic           head_valid;
	b64e_pkg::job_t head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
		end else if (cfg_wr_en) begin
			url_q <= cfg_wr_data;
		end
	end

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.url_safe (url_q),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_ready  (q_ready),
		.in_ready (s_tready),
		.push     (push),
		.push_job (push_job)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the Base64 stream encoder: directed, random and stall tests
module testbench;

	typedef struct packed {
		logic [6:0] code;
		logic       eot;
	} b64_char_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	b64_char_t  pending_chars[$];
	logic [1:0] enc_pos = b64e_pkg::POS_FIRST;
	logic [5:0] enc_carry = '0;
	logic       url_alphabet = 1'b0;
	int         mismatch_count = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         recv_hold_cycles = 0;
	int         bytes_sent = 0;

	base64_stream_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [6:0] sextet_ascii(input logic [5:0] v, input logic url);
		logic [6:0] w;
		w = {1'b0, v};
		if (w < 7'd26)
			return b64e_pkg::CHAR_UPPER_A + w;
		if (w < 7'd52)
			return b64e_pkg::CHAR_LOWER_A + (w - 7'd26);
		if (w < 7'd62)
			return b64e_pkg::CHAR_DIGIT_0 + (w - 7'd52);
		if (w == 7'd62)
			return url ? b64e_pkg::CHAR_MINUS : b64e_pkg::CHAR_PLUS;
		return url ? b64e_pkg::CHAR_UNDERSCORE : b64e_pkg::CHAR_SLASH;
	endfunction

	task automatic encode_byte(input logic [7:0] b, input logic last);
		logic [6:0] chars [4];
		int n;
		n = 0;
		case (enc_pos)
			b64e_pkg::POS_SECOND: begin
				chars[n++] = sextet_ascii({2'b00, b[7:4]} | enc_carry, url_alphabet);
				enc_carry = {b[3:0], 2'b00};
				enc_pos = b64e_pkg::POS_THIRD;
			end
			b64e_pkg::POS_THIRD: begin
				chars[n++] = sextet_ascii({4'b0000, b[7:6]} | enc_carry, url_alphabet);
				chars[n++] = sextet_ascii(b[5:0], url_alphabet);
				enc_carry = '0;
				enc_pos = b64e_pkg::POS_FIRST;
			end
			default: begin
				chars[n++] = sextet_ascii(b[7:2], url_alphabet);
				enc_carry = {b[1:0], 4'b0000};
				enc_pos = b64e_pkg::POS_SECOND;
			end
		endcase
		if (last) begin
			if (enc_pos != b64e_pkg::POS_FIRST) begin
				chars[n++] = sextet_ascii(enc_carry, url_alphabet);
				chars[n++] = b64e_pkg::CHAR_PAD;
				if (enc_pos == b64e_pkg::POS_SECOND)
					chars[n++] = b64e_pkg::CHAR_PAD;
			end
			enc_pos = b64e_pkg::POS_FIRST;
			enc_carry = '0;
		end
		for (int i = 0; i < n; i++)
			pending_chars.insert(pending_chars.size(),
				b64_char_t'{code: chars[i], eot: last && (i == n - 1)});
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		encode_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(255)), i == len - 1);
	endtask

	task automatic wait_drained;
		s_tvalid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_alphabet(input logic url);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= url;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		url_alphabet = url;
	endtask

	task automatic check_char;
		b64_char_t want;
		if (pending_chars.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected char: tdata=%h tlast=%b", m_tdata, m_tlast);
		end else begin
			want = pending_chars.pop_front();
			if (m_tdata !== {1'b0, want.code} || m_tlast !== want.eot) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("char mismatch: expected %h/%b, got %h/%b",
						{1'b0, want.code}, want.eot, m_tdata, m_tlast);
			end
		end
	endtask

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_char();
			if (recv_hold_cycles > 0) begin
				recv_hold_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic test_directed_vectors;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int a = 0; a < 2; a++) begin
			set_alphabet(a[0]);
			send_byte(8'h00, 1'b1);
			send_byte(8'hFF, 1'b0);
			send_byte(8'hFF, 1'b1);
			send_byte(8'hFB, 1'b0);
			send_byte(8'hFF, 1'b0);
			send_byte(8'hBF, 1'b1);
			send_byte(8'hFF, 1'b0);
			send_byte(8'h00, 1'b0);
			send_byte(8'hFF, 1'b0);
			send_byte(8'h00, 1'b1);
		end
	endtask

	task automatic test_random_messages(input int sidle, input int ridle, input int nbytes);
		int start;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) begin
			if ($urandom_range(9) == 0)
				send_message($urandom_range(40, 16));
			else
				send_message($urandom_range(7, 1));
		end
	endtask

	task automatic test_output_stall;
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_cycles = 300;
		send_message(24);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_vectors();
		set_alphabet(1'b1);
		test_random_messages(31, 80, 110);
		set_alphabet(1'b0);
		test_random_messages(80, 31, 110);
		set_alphabet(1'($urandom_range(1)));
		test_random_messages(0, 0, 110);
		test_output_stall();
		wait_drained();

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
